[rtl/midpoint_ellipse_rasterizer_macros.svh]
// Assertion macros shared by the ellipse rasterizer checkers.
// Depends on nothing; included by the checker file.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Clocked property with a reset guard.
`define MER_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define MER_NEVER(lbl, ck, rs, cond, msg) \
  `MER_ASSERT(lbl, ck, rs, !(cond), msg)

`endif

[rtl/mer_pkg.sv]
// Shared widths, command and status types for the midpoint ellipse rasterizer.
// Depends on nothing; used by the datapath, the controller and the top level.
`default_nettype none

package mer_pkg;

  // Frame and coordinate geometry.
  localparam int FRAME_SIDE = 32;
  localparam int CW  = 5;   // coordinate and radius width
  localparam int SQW = 8;   // width of a squared radius
  localparam int XW  = 6;   // horizontal offset, unsigned
  localparam int YW  = 7;   // vertical offset, signed (reaches -1)
  localparam int GW  = 16;  // gradients, signed
  localparam int DW  = 24;  // scaled decision variable, signed
  localparam int NW  = 7;   // result counter, holds the step limit
  localparam int PCW = 9;   // signed width of an unwrapped point coordinate
  localparam int MBW = 9;   // signed width of the second multiplier operand

  // Operand pairs for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_SQ,
    MUL_RY_SQ,
    MUL_AA_RY,
    MUL_BB_T,
    MUL_P_T,
    MUL_YM1_SQ,
    MUL_AA_P,
    MUL_AA_BB
  } mul_sel_t;

  // Register loads taken from the product register.
  typedef enum logic [2:0] {
    LD_NONE,
    LD_AA,
    LD_BB,
    LD_INIT,
    LD_D_P,
    LD_D_ADD4,
    LD_D_SUB4
  } ld_sel_t;

  typedef struct packed {
    logic     load_geom;
    mul_sel_t mul_sel;
    ld_sel_t  ld_sel;
    logic     step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic more;      // another step follows the one being taken
    logic to_r2;     // the step being taken leaves region one
    logic init_r1;   // region one has at least one step (valid at end of setup)
  } dp_stat_t;

  // True when an unwrapped point lies on the frame.
  function automatic logic on_frame(input logic signed [PCW-1:0] px,
                                    input logic signed [PCW-1:0] py);
    on_frame = (px >= 0) && (px < FRAME_SIDE) && (py >= 0) && (py < FRAME_SIDE);
  endfunction

endpackage

`default_nettype wire

[rtl/mer_datapath.sv]
// Datapath of the ellipse rasterizer: geometry, shared multiplier, walk state
// and the output register. Depends on mer_pkg; driven by mer_ctrl.
`default_nettype none

module mer_datapath import mer_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dp_cmd_t         cmd,
  output dp_stat_t             stat,
  input  wire logic [CW-1:0]   corner_a_x,
  input  wire logic [CW-1:0]   corner_a_y,
  input  wire logic [CW-1:0]   corner_b_x,
  input  wire logic [CW-1:0]   corner_b_y,
  input  wire logic [31:0]     paint_rgba,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [CW-1:0]        pt0_x,
  output logic [CW-1:0]        pt0_y,
  output logic [CW-1:0]        pt1_x,
  output logic [CW-1:0]        pt1_y,
  output logic [CW-1:0]        pt2_x,
  output logic [CW-1:0]        pt2_y,
  output logic [CW-1:0]        pt3_x,
  output logic [CW-1:0]        pt3_y,
  output logic [3:0]           inside_mask,
  output logic [31:0]          pixel_rgba,
  output logic                 last_step
);

  // Geometry and walk registers.
  logic [CW-1:0]          cx, cy, rx, ry;
  logic [31:0]            color;
  logic [SQW-1:0]         aa, bb;
  logic signed [DW-1:0]   prod;
  logic [XW-1:0]          x;
  logic signed [YW-1:0]   y;
  logic signed [GW-1:0]   gx, gy;
  logic signed [DW-1:0]   d;
  logic                   r2;
  logic [NW-1:0]          n;

  // Bounding box, radii and center of the incoming corners.
  logic [CW-1:0] xmin, xmax, ymin, ymax, rx_in, ry_in;
  always_comb begin
    xmin  = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
    xmax  = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
    ymin  = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
    ymax  = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
    rx_in = (xmax - xmin) >> 1;
    ry_in = (ymax - ymin) >> 1;
  end

  // Shared multiplier operand selection.
  logic signed [DW-1:0]    mul_a;
  logic signed [MBW-1:0]   mul_b;
  logic signed [MBW-1:0]   t_ext, ym1;
  logic signed [DW+MBW-1:0] mul_full;
  always_comb begin
    t_ext = $signed({2'b00, x, 1'b1});
    ym1   = MBW'(y) - MBW'(1);
    case (cmd.mul_sel)
      MUL_RX_SQ:  begin mul_a = DW'(rx);   mul_b = MBW'(rx);  end
      MUL_RY_SQ:  begin mul_a = DW'(ry);   mul_b = MBW'(ry);  end
      MUL_AA_RY:  begin mul_a = DW'(aa);   mul_b = MBW'(ry);  end
      MUL_BB_T:   begin mul_a = DW'(bb);   mul_b = t_ext;     end
      MUL_P_T:    begin mul_a = prod;      mul_b = t_ext;     end
      MUL_YM1_SQ: begin mul_a = DW'(ym1);  mul_b = ym1;       end
      MUL_AA_P:   begin mul_a = prod;      mul_b = MBW'(aa);  end
      MUL_AA_BB:  begin mul_a = DW'(aa);   mul_b = MBW'(bb);  end
      default:    begin mul_a = '0;        mul_b = '0;        end
    endcase
    mul_full = mul_a * mul_b;
  end

  // One walk step: next offsets, gradients and decision.
  logic signed [GW-1:0] gxs, gys, gx_next, gy_next;
  logic signed [DW-1:0] gx4, gy4, aa4, bb4, d_next;
  logic [XW-1:0]        x_next;
  logic signed [YW-1:0] y_next;
  logic [NW-1:0]        n_next;
  always_comb begin
    gxs = gx + GW'({bb, 1'b0});
    gys = gy - GW'({aa, 1'b0});
    gx4 = DW'(gxs) <<< 2;
    gy4 = DW'(gys) <<< 2;
    aa4 = DW'({aa, 2'b00});
    bb4 = DW'({bb, 2'b00});
    if (!r2) begin
      x_next  = x + XW'(1);
      gx_next = gxs;
      if (d[DW-1]) begin
        y_next  = y;
        gy_next = gy;
        d_next  = d + gx4 + bb4;
      end else begin
        y_next  = y - YW'(1);
        gy_next = gys;
        d_next  = d + gx4 - gy4 + bb4;
      end
    end else begin
      y_next  = y - YW'(1);
      gy_next = gys;
      if (d > 0) begin
        x_next  = x;
        gx_next = gx;
        d_next  = d + aa4 - gy4;
      end else begin
        x_next  = x + XW'(1);
        gx_next = gxs;
        d_next  = d + gx4 - gy4 + aa4;
      end
    end
    n_next = n + NW'(1);
  end

  // Status toward the controller.
  always_comb begin
    stat.out_free = !out_valid || out_ready;
    stat.to_r2    = !r2 && !(gx_next < gy_next);
    stat.more     = !n_next[NW-1] && ((!r2 && (gx_next < gy_next)) || !y_next[YW-1]);
    stat.init_r1  = (prod != '0);
  end

  // Four mirrored points of the current step, unwrapped.
  logic signed [PCW-1:0] xp, xm, yp, ym;
  always_comb begin
    xp = $signed(PCW'(cx)) + $signed(PCW'(x));
    xm = $signed(PCW'(cx)) - $signed(PCW'(x));
    yp = $signed(PCW'(cy)) + PCW'(y);
    ym = $signed(PCW'(cy)) - PCW'(y);
  end

  // Geometry capture, multiplier product and walk state.
  always_ff @(posedge clk) begin
    if (cmd.load_geom) begin
      rx    <= rx_in;
      ry    <= ry_in;
      cx    <= xmin + rx_in;
      cy    <= ymin + ry_in;
      color <= paint_rgba;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_full[DW-1:0];
    end
    case (cmd.ld_sel)
      LD_AA: aa <= prod[SQW-1:0];
      LD_BB: bb <= prod[SQW-1:0];
      LD_INIT: begin
        x  <= '0;
        y  <= YW'(ry);
        gx <= '0;
        gy <= {prod[GW-2:0], 1'b0};
        d  <= bb4 - (prod <<< 2) + DW'(aa);
        r2 <= 1'b0;
        n  <= '0;
      end
      LD_D_P:    d <= prod;
      LD_D_ADD4: d <= d + (prod <<< 2);
      LD_D_SUB4: begin
        d  <= d - (prod <<< 2);
        r2 <= 1'b1;
      end
      default: ;
    endcase
    if (cmd.step) begin
      x  <= x_next;
      y  <= y_next;
      gx <= gx_next;
      gy <= gy_next;
      d  <= d_next;
      n  <= n_next;
    end
  end

  // Output register: loads one beat per step, clears when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.step) begin
      pt0_x       <= xp[CW-1:0];
      pt0_y       <= yp[CW-1:0];
      pt1_x       <= xp[CW-1:0];
      pt1_y       <= ym[CW-1:0];
      pt2_x       <= xm[CW-1:0];
      pt2_y       <= yp[CW-1:0];
      pt3_x       <= xm[CW-1:0];
      pt3_y       <= ym[CW-1:0];
      inside_mask <= {on_frame(xm, ym), on_frame(xm, yp),
                      on_frame(xp, ym), on_frame(xp, yp)};
      pixel_rgba  <= color;
      last_step   <= !stat.more;
    end
  end

endmodule

`default_nettype wire

[rtl/mer_ctrl.sv]
// Controller of the ellipse rasterizer: sequences setup, region change and steps.
// Depends on mer_pkg; commands mer_datapath.
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET0,
    S_SET1,
    S_SET2,
    S_SET3,
    S_STEP,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_R5
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd.load_geom = 1'b0;
    cmd.mul_sel   = MUL_NONE;
    cmd.ld_sel    = LD_NONE;
    cmd.step      = 1'b0;
    state_next    = state;
    case (state)
      S_IDLE: begin
        cmd.load_geom = in_valid;
        if (in_valid) state_next = S_SET0;
      end
      S_SET0: begin
        cmd.mul_sel = MUL_RX_SQ;
        state_next  = S_SET1;
      end
      S_SET1: begin
        cmd.ld_sel  = LD_AA;
        cmd.mul_sel = MUL_RY_SQ;
        state_next  = S_SET2;
      end
      S_SET2: begin
        cmd.ld_sel  = LD_BB;
        cmd.mul_sel = MUL_AA_RY;
        state_next  = S_SET3;
      end
      S_SET3: begin
        // A zero vertical gradient skips region one entirely.
        cmd.ld_sel = LD_INIT;
        state_next = stat.init_r1 ? S_STEP : S_R0;
      end
      S_STEP: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (!stat.more)      state_next = S_IDLE;
          else if (stat.to_r2) state_next = S_R0;
        end
      end
      S_R0: begin
        cmd.mul_sel = MUL_BB_T;
        state_next  = S_R1;
      end
      S_R1: begin
        cmd.mul_sel = MUL_P_T;
        state_next  = S_R2;
      end
      S_R2: begin
        cmd.ld_sel  = LD_D_P;
        cmd.mul_sel = MUL_YM1_SQ;
        state_next  = S_R3;
      end
      S_R3: begin
        cmd.mul_sel = MUL_AA_P;
        state_next  = S_R4;
      end
      S_R4: begin
        cmd.ld_sel  = LD_D_ADD4;
        cmd.mul_sel = MUL_AA_BB;
        state_next  = S_R5;
      end
      S_R5: begin
        cmd.ld_sel = LD_D_SUB4;
        state_next = S_STEP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer: one beat in, one beat out per walk step.
// The first result is registered by the first walk step, after setup in S_SET0 to S_SET3,
// and also after S_R0 to S_R5 when region one is empty and the walk starts in region two.
// One step per cycle while the output register is free; entering region two passes through
// S_R0 to S_R5, and no new item is taken until the walk has issued its last step.
// Reset is synchronous, active high, and clears the controller and output valid.
`default_nettype none

module midpoint_ellipse_rasterizer import mer_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [CW-1:0] corner_a_x,
  input  wire logic [CW-1:0] corner_a_y,
  input  wire logic [CW-1:0] corner_b_x,
  input  wire logic [CW-1:0] corner_b_y,
  input  wire logic [31:0]   paint_rgba,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [CW-1:0]      pt0_x,
  output logic [CW-1:0]      pt0_y,
  output logic [CW-1:0]      pt1_x,
  output logic [CW-1:0]      pt1_y,
  output logic [CW-1:0]      pt2_x,
  output logic [CW-1:0]      pt2_y,
  output logic [CW-1:0]      pt3_x,
  output logic [CW-1:0]      pt3_y,
  output logic [3:0]         inside_mask,
  output logic [31:0]        pixel_rgba,
  output logic               last_step
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  mer_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .corner_a_x  (corner_a_x),
    .corner_a_y  (corner_a_y),
    .corner_b_x  (corner_b_x),
    .corner_b_y  (corner_b_y),
    .paint_rgba  (paint_rgba),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .pt0_x       (pt0_x),
    .pt0_y       (pt0_y),
    .pt1_x       (pt1_x),
    .pt1_y       (pt1_y),
    .pt2_x       (pt2_x),
    .pt2_y       (pt2_y),
    .pt3_x       (pt3_x),
    .pt3_y       (pt3_y),
    .inside_mask (inside_mask),
    .pixel_rgba  (pixel_rgba),
    .last_step   (last_step)
  );

endmodule

`default_nettype wire

[rtl/mer_checker.sv]
// Port-level checks for the ellipse rasterizer, bound to the top level.
// Depends on midpoint_ellipse_rasterizer_macros.svh.
`default_nettype none
`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  pt0_x,
  input wire logic [31:0] pixel_rgba,
  input wire logic        last_step
);

  // A stalled output beat stays up.
  `MER_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "output beat dropped")

  // A stalled output beat keeps its payload.
  `MER_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(pt0_x) && $stable(pixel_rgba) && $stable(last_step), "stalled beat changed")

  // While a non-final beat waits, the walk is still running and takes no input.
  `MER_NEVER(a_busy_walk, clk, rst, out_valid && !last_step && in_ready, "input taken mid-walk")

  // Taking an input starts a walk, so the input side closes next cycle.
  `MER_ASSERT(a_in_close, clk, rst, in_valid && in_ready |=> !in_ready, "input stayed open")

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pt0_x      (pt0_x),
  .pixel_rgba (pixel_rgba),
  .last_step  (last_step)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_ellipse_rasterizer: drives corner pairs and colors,
// predicts every walk step in a behavioral model and checks each output beat in order.
// Depends on mer_pkg and the midpoint_ellipse_rasterizer RTL.

module tb;
  import mer_pkg::*;

  localparam int WALK_LIMIT   = 64;    // most steps one ellipse may emit
  localparam int RANDOM_ITEMS = 460;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [31:0]   color;
  } shape_t;

  typedef struct packed {
    logic [3:0][CW-1:0] x;
    logic [3:0][CW-1:0] y;
    logic [3:0]         mask;
    logic [31:0]        color;
    logic               last;
  } plot_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [CW-1:0] corner_a_x = '0;
  logic [CW-1:0] corner_a_y = '0;
  logic [CW-1:0] corner_b_x = '0;
  logic [CW-1:0] corner_b_y = '0;
  logic [31:0]   paint_rgba = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y;
  logic [3:0]    inside_mask;
  logic [31:0]   pixel_rgba;
  logic          last_step;

  shape_t shape_queue[$];   // shapes not yet offered to the block
  plot_t  walk_beats[$];    // predicted step beats, oldest first
  shape_t offer;
  int     total_shapes = 0;
  int     shapes_taken = 0;
  int     beats_seen = 0;
  int     errors = 0;

  midpoint_ellipse_rasterizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
    .corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
    .paint_rgba(paint_rgba),
    .out_valid(out_valid), .out_ready(out_ready),
    .pt0_x(pt0_x), .pt0_y(pt0_y), .pt1_x(pt1_x), .pt1_y(pt1_y),
    .pt2_x(pt2_x), .pt2_y(pt2_y), .pt3_x(pt3_x), .pt3_y(pt3_y),
    .inside_mask(inside_mask), .pixel_rgba(pixel_rgba), .last_step(last_step)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Builds one step beat: the four mirrored points around the center.
  function automatic plot_t make_plot(input int cx, input int cy, input int ox, input int oy,
                                      input logic [31:0] color);
    plot_t p;
    int    px [4];
    int    py [4];
    px[0] = cx + ox; py[0] = cy + oy;
    px[1] = cx + ox; py[1] = cy - oy;
    px[2] = cx - ox; py[2] = cy + oy;
    px[3] = cx - ox; py[3] = cy - oy;
    for (int i = 0; i < 4; i++) begin
      p.x[i] = CW'(px[i]);
      p.y[i] = CW'(py[i]);
      p.mask[i] = (px[i] >= 0) && (px[i] < FRAME_SIDE) && (py[i] >= 0) && (py[i] < FRAME_SIDE);
    end
    p.color = color;
    p.last = 1'b0;
    return p;
  endfunction

  // Walks both regions of the midpoint ellipse for one shape and queues every step.
  // The decision variable is carried at four times its value so it stays integral.
  function automatic void trace_ellipse(input shape_t s);
    int    xlo, xhi, ylo, yhi, rx, ry, cx, cy, rx_sq, ry_sq, span, count;
    int    ox, oy, gx, gy, dec;
    plot_t walk[$];
    xlo = (s.ax < s.bx) ? s.ax : s.bx;
    xhi = (s.ax < s.bx) ? s.bx : s.ax;
    ylo = (s.ay < s.by) ? s.ay : s.by;
    yhi = (s.ay < s.by) ? s.by : s.ay;
    rx = (xhi - xlo) / 2;
    ry = (yhi - ylo) / 2;
    cx = xlo + rx;
    cy = ylo + ry;
    rx_sq = rx * rx;
    ry_sq = ry * ry;
    count = 0;
    ox = 0;
    oy = ry;
    gx = 0;
    gy = 2 * rx_sq * ry;
    dec = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;

    // Region one: slope shallower than one, x advances every step.
    while (gx < gy && count < WALK_LIMIT) begin
      walk.insert(walk.size(), make_plot(cx, cy, ox, oy, s.color));
      count++;
      ox++;
      gx += 2 * ry_sq;
      if (dec < 0) begin
        dec += 4 * gx + 4 * ry_sq;
      end else begin
        oy--;
        gy -= 2 * rx_sq;
        dec += 4 * gx - 4 * gy + 4 * ry_sq;
      end
    end

    // Region two: y falls every step until it passes zero.
    span = 2 * ox + 1;
    dec = ry_sq * span * span + 4 * rx_sq * (oy - 1) * (oy - 1) - 4 * rx_sq * ry_sq;
    while (oy >= 0 && count < WALK_LIMIT) begin
      walk.insert(walk.size(), make_plot(cx, cy, ox, oy, s.color));
      count++;
      oy--;
      gy -= 2 * rx_sq;
      if (dec > 0) begin
        dec += 4 * rx_sq - 4 * gy;
      end else begin
        ox++;
        gx += 2 * ry_sq;
        dec += 4 * gx - 4 * gy + 4 * rx_sq;
      end
    end

    if (walk.size() > 0) walk[walk.size() - 1].last = 1'b1;
    foreach (walk[i]) walk_beats.insert(walk_beats.size(), walk[i]);
  endfunction

  function automatic void add_shape(input int ax, input int ay, input int bx, input int by,
                                    input logic [31:0] color);
    shape_t s;
    s.ax = CW'(ax);
    s.ay = CW'(ay);
    s.bx = CW'(bx);
    s.by = CW'(by);
    s.color = color;
    shape_queue.insert(shape_queue.size(), s);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: offers queued shapes, holding each one steady until it is taken.
  int send_gap = 0;
  bit send_steady = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        trace_ellipse(offer);
        shapes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (shape_queue.size() > 0) begin
          offer = shape_queue.pop_front();
          corner_a_x <= offer.ax;
          corner_a_y <= offer.ay;
          corner_b_x <= offer.bx;
          corner_b_y <= offer.by;
          paint_rgba <= offer.color;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each step beat against the oldest prediction and
  // throttles ready, including one long hold-off so the block backs up.
  int  hold_count = 0;
  bit  recv_steady = 1'b0;
  bit  pressure_done = 1'b0;
  plot_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (walk_beats.size() == 0) begin
          $display("%0t ns: step beat with no prediction waiting", $time);
          errors++;
        end else begin
          want = walk_beats.pop_front();
          check_field("pt0_x", want.x[0], pt0_x);
          check_field("pt0_y", want.y[0], pt0_y);
          check_field("pt1_x", want.x[1], pt1_x);
          check_field("pt1_y", want.y[1], pt1_y);
          check_field("pt2_x", want.x[2], pt2_x);
          check_field("pt2_y", want.y[2], pt2_y);
          check_field("pt3_x", want.x[3], pt3_x);
          check_field("pt3_y", want.y[3], pt3_y);
          check_field("inside_mask", want.mask, inside_mask);
          check_field("pixel_rgba", want.color, pixel_rgba);
          check_field("last_step", want.last, last_step);
        end
      end
      if (!pressure_done && beats_seen >= 300) begin
        pressure_done = 1'b1;
        hold_count = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) recv_steady = !recv_steady;
      if (hold_count > 0) begin
        hold_count--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_steady && $urandom_range(0, 99) < 25) hold_count = pick_gap();
      end
    end
  end

  // Watchdog: a long run of cycles without any beat means the block hung.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int kind;
    int ax, ay, bx, by;
    logic [31:0] color;

    // Directed: extremes, degenerate radii, off-frame overshoot and color edges.
    add_shape(0, 0, 0, 0, 32'h0000_0000);
    add_shape(0, 0, 31, 31, 32'hFFFF_FFFF);
    add_shape(31, 31, 0, 0, 32'hAAAA_AAAA);
    add_shape(31, 0, 0, 31, 32'h5555_5555);
    add_shape(5, 0, 5, 31, 32'h1234_5678);
    add_shape(6, 31, 5, 0, 32'h8765_4321);
    add_shape(0, 10, 31, 10, 32'hFF00_FF00);
    add_shape(31, 11, 0, 10, 32'h00FF_00FF);
    add_shape(10, 10, 12, 12, 32'hDEAD_BEEF);
    add_shape(10, 10, 13, 13, 32'hCAFE_F00D);
    add_shape(0, 0, 31, 2, 32'h0F0F_0F0F);
    add_shape(0, 0, 2, 31, 32'hF0F0_F0F0);
    add_shape(0, 0, 30, 30, 32'h8000_0001);
    add_shape(1, 1, 31, 31, 32'h7FFF_FFFE);
    add_shape(31, 31, 31, 31, 32'h0000_0001);
    add_shape(0, 31, 31, 0, 32'h8000_0000);
    add_shape(16, 0, 16, 0, 32'hFFFF_FFFE);
    add_shape(20, 3, 27, 28, 32'h0102_0304);
    add_shape(3, 20, 28, 27, 32'hA5A5_5A5A);
    add_shape(0, 15, 1, 16, 32'h3C3C_C3C3);

    // Random shapes: mostly free corners, some pinned to the frame edges,
    // some with zero or tiny radii.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      ax = $urandom_range(0, 31);
      ay = $urandom_range(0, 31);
      bx = $urandom_range(0, 31);
      by = $urandom_range(0, 31);
      color = $urandom;
      if (kind == 6 || kind == 7) begin
        ax = $urandom_range(0, 1) ? 31 : 0;
        by = $urandom_range(0, 1) ? 31 : 0;
      end else if (kind == 8) begin
        bx = ax + $urandom_range(0, 1);
        if (bx > 31) bx = 31;
      end else if (kind == 9) begin
        by = ay + $urandom_range(0, 3);
        if (by > 31) by = 31;
      end
      add_shape(ax, ay, bx, by, color);
    end
    total_shapes = shape_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (shapes_taken < total_shapes || walk_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
